>>> rtl/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W     = 6;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int DAYNUM_W  = 23;
    localparam int COUNT_W   = 22;
    localparam int MLEN_W    = 5;
    localparam int MBEFORE_W = 9;
    localparam int CENT_W    = 8;

    // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit x
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ORDER_FIRST  = 2'd0,
        ORDER_SECOND = 2'd1,
        ORDER_EQUAL  = 2'd2
    } t_order;

    function automatic logic [MBEFORE_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MBEFORE_W-1:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [MLEN_W-1:0] v;
        case (m)
            4'd2:    v = leap ? 5'd29 : 5'd28;
            4'd4:    v = 5'd30;
            4'd6:    v = 5'd30;
            4'd9:    v = 5'd30;
            4'd11:   v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/gdd_date_unit.sv
`timescale 1ns / 1ps

module gdd_date_unit #(
    parameter int MAX_YEAR = 9999
) (
    input  logic [gdd_pkg::DAY_W-1:0]    i_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year,
    output logic                         o_valid,
    output logic [gdd_pkg::DAYNUM_W-1:0] o_day_num
);
    import gdd_pkg::*;

    logic [YEAR_W-1:0]      prev_year;
    logic [DIV100_PW-1:0]   prod_p;
    logic [DIV100_PW-1:0]   prod_y;
    logic [CENT_W-1:0]      cent_p;
    logic [CENT_W-1:0]      cent_y;
    logic                   century;
    logic                   leap;
    logic [MLEN_W-1:0]      mlen;
    logic [DAYNUM_W-1:0]    year_days;
    logic [DAYNUM_W-1:0]    year_part;

    assign prev_year = i_year - YEAR_W'(1);

    assign prod_p = DIV100_PW'(prev_year) * DIV100_PW'(DIV100_MUL);
    assign prod_y = DIV100_PW'(i_year) * DIV100_PW'(DIV100_MUL);
    assign cent_p = CENT_W'(prod_p >> DIV100_SHIFT);
    assign cent_y = CENT_W'(prod_y >> DIV100_SHIFT);

    // the year is a multiple of 100 exactly when floor(y/100) steps up from y-1
    assign century = (cent_y != cent_p);
    assign leap    = ((i_year[1:0] == 2'b00) && !century) || (century && (cent_y[1:0] == 2'b00));

    assign mlen = month_length(i_month, leap);

    assign o_valid = (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC)
                  && (i_year != '0) && (i_year <= YEAR_W'(MAX_YEAR))
                  && (i_day != '0) && (DAY_W'(mlen) >= i_day);

    assign year_days = DAYNUM_W'(prev_year) * DAYNUM_W'(365);
    assign year_part = year_days + DAYNUM_W'(prev_year >> 2) - DAYNUM_W'(cent_p)
                     + DAYNUM_W'(cent_p >> 2);

    assign o_day_num = year_part + DAYNUM_W'(days_before_month(i_month))
                     + DAYNUM_W'((i_month > MONTH_FEB) && leap)
                     + DAYNUM_W'(i_day) - DAYNUM_W'(1);

endmodule

>>> rtl/gregorian_date_difference_core.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------------
// input     | start, busy          | i_day/month/year_first, i_day/month/year_second
// result    | o_done (strobe)      | o_first_valid, o_second_valid, o_order, o_day_count
//
// one date pair per cycle; busy is never raised
// a result strobes o_done once its start has passed the input register, then the result register
// the per-cycle figure is set by the day-number path (a 14x13 reciprocal multiply for the
// century count, then adds, the difference and the saturation compare)
// synchronous active-low reset clears only the valid flags of both registers
// the receiver cannot stall, so nothing is held back

module gregorian_date_difference_core #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gdd_pkg::DAY_W-1:0]    i_day_first,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month_first,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year_first,
    input  logic [gdd_pkg::DAY_W-1:0]    i_day_second,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month_second,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year_second,
    output logic                         o_done,
    output logic                         o_first_valid,
    output logic                         o_second_valid,
    output gdd_pkg::t_order              o_order,
    output logic [gdd_pkg::COUNT_W-1:0]  o_day_count
);
    import gdd_pkg::*;

    localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;

    logic                 r_in_vld;
    logic [DAY_W-1:0]     r_day_a;
    logic [MONTH_W-1:0]   r_month_a;
    logic [YEAR_W-1:0]    r_year_a;
    logic [DAY_W-1:0]     r_day_b;
    logic [MONTH_W-1:0]   r_month_b;
    logic [YEAR_W-1:0]    r_year_b;

    logic                 r_done;
    logic                 r_first_valid;
    logic                 r_second_valid;
    t_order               r_order;
    logic [COUNT_W-1:0]   r_day_count;

    logic                 valid_a;
    logic                 valid_b;
    logic [DAYNUM_W-1:0]  num_a;
    logic [DAYNUM_W-1:0]  num_b;
    logic [KEY_W-1:0]     key_a;
    logic [KEY_W-1:0]     key_b;
    logic [DAYNUM_W-1:0]  diff;
    t_order               n_order;
    logic [COUNT_W-1:0]   n_day_count;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= start;
            r_done   <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_day_a   <= i_day_first;
            r_month_a <= i_month_first;
            r_year_a  <= i_year_first;
            r_day_b   <= i_day_second;
            r_month_b <= i_month_second;
            r_year_b  <= i_year_second;
        end
        if (r_in_vld) begin
            r_first_valid  <= valid_a;
            r_second_valid <= valid_b;
            r_order        <= n_order;
            r_day_count    <= n_day_count;
        end
    end

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_date_a (
        .i_day     (r_day_a),
        .i_month   (r_month_a),
        .i_year    (r_year_a),
        .o_valid   (valid_a),
        .o_day_num (num_a)
    );

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_date_b (
        .i_day     (r_day_b),
        .i_month   (r_month_b),
        .i_year    (r_year_b),
        .o_valid   (valid_b),
        .o_day_num (num_b)
    );

    // ordering uses the raw fields whether or not the dates are real
    assign key_a = {r_year_a, r_month_a, r_day_a};
    assign key_b = {r_year_b, r_month_b, r_day_b};

    always_comb begin
        if (key_a < key_b) begin
            n_order = ORDER_FIRST;
        end else if (key_a > key_b) begin
            n_order = ORDER_SECOND;
        end else begin
            n_order = ORDER_EQUAL;
        end
    end

    assign diff = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);

    always_comb begin
        if (!(valid_a && valid_b)) begin
            n_day_count = '0;
        end else if (diff > DAYNUM_W'(COUNT_MAX)) begin
            n_day_count = COUNT_MAX;
        end else begin
            n_day_count = COUNT_W'(diff);
        end
    end

    assign o_done         = r_done;
    assign o_first_valid  = r_first_valid;
    assign o_second_valid = r_second_valid;
    assign o_order        = r_order;
    assign o_day_count    = r_day_count;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 2))
        else $error("result strobe without a transaction two cycles earlier");

    a_count_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !(o_first_valid && o_second_valid) |-> o_day_count == '0)
        else $error("nonzero day count with an invalid date");

    a_equal_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_order == ORDER_EQUAL |-> o_day_count == '0
            && o_first_valid == o_second_valid)
        else $error("equal dates give a nonzero count or differing validity");

    a_distinct_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_first_valid && o_second_valid && o_order != ORDER_EQUAL
            |-> o_day_count != '0)
        else $error("distinct valid dates give a zero day count");

endmodule
